// ----- rtl/core/sma_pkg.sv -----
// Shared types and constants for the store-multiple address sequencer.
// Control word layout, step codes and jump conditions of the microprogram.
// No dependencies.
package sma_pkg;

    // Field widths
    localparam int LIST_BITS     = 15;
    localparam int REG_COUNT_DEF = 15;
    localparam int REG_W         = 4;
    localparam int ADDR_W        = 32;
    localparam int CNT_W         = 4;
    localparam int WORD_BYTES    = 4;

    // Stream widths, whole bytes
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;

    // Microprogram step addresses
    typedef logic [2:0] t_step;
    localparam t_step STEP_IDLE  = 3'd0;
    localparam t_step STEP_COUNT = 3'd1;
    localparam t_step STEP_ADDR  = 3'd2;
    localparam t_step STEP_EMIT  = 3'd3;
    localparam t_step STEP_EMPTY = 3'd4;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN_ACC,
        COND_MASK_EMPTY,
        COND_OUT_ACC,
        COND_OUT_LAST
    } t_cond;

    // One control word
    typedef struct packed {
        logic  in_ready;    // take a request
        logic  load;        // latch request fields
        logic  count;       // count listed registers, work out flags
        logic  addr;        // work out start address and writeback value
        logic  emit;        // present one store per listed register
        logic  emit_empty;  // present the lone no-store result
        t_cond cond;        // jump condition
        t_step target;      // jump target
        logic  seq;         // on no jump: 1 = next step, 0 = hold
    } t_ctrl;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic in_acc;
        logic out_acc;
        logic mask_empty;
        logic last_item;
    } t_status;

endpackage

// ----- rtl/core/store_multiple_address_sequencer.sv -----
// Top level of the store-multiple address sequencer.
// Instantiates sma_sequencer and sma_datapath; depends on sma_pkg.
//
// Takes one store-multiple request and turns it into one word-store result per
// listed register, lowest register first, the last one marked with tlast; an
// empty list gives a single result without a store. Requests are handled one
// at a time. The microprogram has one accept step, a popcount step, an address
// setup step, then one emit step per result (at least one result), each held
// while the downstream side stalls.
module store_multiple_address_sequencer #(
    parameter int REG_COUNT = sma_pkg::REG_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [3:0] base_reg, [35:4] base_value, [50:36] reg_list, [51] write_back
    input  logic [sma_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] store_address, [35:32] source_reg, [36] unsupported,
    // [37] wb_enable, [69:38] wb_value
    output logic [sma_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] store_valid
    output logic [0:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);

    sma_pkg::t_ctrl              ctrl;
    sma_pkg::t_status            status;
    logic                        store_valid;
    logic [sma_pkg::ADDR_W-1:0]  store_address;
    logic [sma_pkg::REG_W-1:0]   source_reg;
    logic                        unsupported;
    logic                        wb_enable;
    logic [sma_pkg::ADDR_W-1:0]  wb_value;

    sma_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    sma_datapath #(
        .REG_COUNT (REG_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_ctrl          (ctrl),
        .i_in_valid      (s_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .i_req_type      (s_axis_tuser[0]),
        .i_base_reg      (s_axis_tdata[3:0]),
        .i_base_value    (s_axis_tdata[35:4]),
        .i_reg_list      (s_axis_tdata[50:36]),
        .i_write_back    (s_axis_tdata[51]),
        .o_store_valid   (store_valid),
        .o_store_address (store_address),
        .o_source_reg    (source_reg),
        .o_unsupported   (unsupported),
        .o_wb_enable     (wb_enable),
        .o_wb_value      (wb_value),
        .o_last          (m_axis_tlast),
        .o_status        (status)
    );

    // stream handshakes
    assign s_axis_tready = ctrl.in_ready;
    assign m_axis_tvalid = ctrl.emit | ctrl.emit_empty;

    assign m_axis_tuser = store_valid;
    assign m_axis_tdata = {2'b00, wb_value, wb_enable, unsupported, source_reg, store_address};

endmodule

// ----- rtl/core/sma_ucode_rom.sv -----
// Microprogram ROM: one control word per step.
// Depends on sma_pkg.
module sma_ucode_rom (
    input  sma_pkg::t_step i_step,
    output sma_pkg::t_ctrl o_ctrl
);

    always_comb begin
        o_ctrl = '0;
        case (i_step)
            // wait for a request and latch it
            sma_pkg::STEP_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.load     = 1'b1;
                o_ctrl.cond     = sma_pkg::COND_IN_ACC;
                o_ctrl.target   = sma_pkg::STEP_COUNT;
            end
            // popcount of the list, unsupported flag
            sma_pkg::STEP_COUNT: begin
                o_ctrl.count  = 1'b1;
                o_ctrl.cond   = sma_pkg::COND_ALWAYS;
                o_ctrl.target = sma_pkg::STEP_ADDR;
            end
            // start address and writeback value; empty list branches off
            sma_pkg::STEP_ADDR: begin
                o_ctrl.addr   = 1'b1;
                o_ctrl.cond   = sma_pkg::COND_MASK_EMPTY;
                o_ctrl.target = sma_pkg::STEP_EMPTY;
                o_ctrl.seq    = 1'b1;
            end
            // one store per cycle while results are taken, until the last is taken
            sma_pkg::STEP_EMIT: begin
                o_ctrl.emit   = 1'b1;
                o_ctrl.cond   = sma_pkg::COND_OUT_LAST;
                o_ctrl.target = sma_pkg::STEP_IDLE;
            end
            sma_pkg::STEP_EMPTY: begin
                o_ctrl.emit_empty = 1'b1;
                o_ctrl.cond       = sma_pkg::COND_OUT_ACC;
                o_ctrl.target     = sma_pkg::STEP_IDLE;
            end
            default: begin
                o_ctrl.cond   = sma_pkg::COND_ALWAYS;
                o_ctrl.target = sma_pkg::STEP_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/sma_sequencer.sv -----
// Step counter with conditional jumps over the microprogram ROM.
// Depends on sma_pkg and sma_ucode_rom.
module sma_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sma_pkg::t_status i_status,
    output sma_pkg::t_ctrl   o_ctrl
);

    sma_pkg::t_step r_step;
    sma_pkg::t_step n_step;
    logic           jump;

    sma_ucode_rom u_rom (
        .i_step (r_step),
        .o_ctrl (o_ctrl)
    );

    // condition select
    always_comb begin
        case (o_ctrl.cond)
            sma_pkg::COND_NEVER:      jump = 1'b0;
            sma_pkg::COND_ALWAYS:     jump = 1'b1;
            sma_pkg::COND_IN_ACC:     jump = i_status.in_acc;
            sma_pkg::COND_MASK_EMPTY: jump = i_status.mask_empty;
            sma_pkg::COND_OUT_ACC:    jump = i_status.out_acc;
            sma_pkg::COND_OUT_LAST:   jump = i_status.out_acc & i_status.last_item;
            default:                  jump = 1'b0;
        endcase
    end

    // next step: jump, advance or hold
    always_comb begin
        if (jump) begin
            n_step = o_ctrl.target;
        end else if (o_ctrl.seq) begin
            n_step = r_step + 3'd1;
        end else begin
            n_step = r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= sma_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- rtl/core/sma_datapath.sv -----
// Datapath: request latches, register list mask, address counter, result fields.
// Driven by control words from sma_sequencer; depends on sma_pkg.
module sma_datapath #(
    parameter int REG_COUNT = sma_pkg::REG_COUNT_DEF
) (
    input  logic                        i_clk,
    input  sma_pkg::t_ctrl              i_ctrl,
    input  logic                        i_in_valid,
    input  logic                        i_out_ready,
    input  logic                        i_req_type,
    input  logic [sma_pkg::REG_W-1:0]   i_base_reg,
    input  logic [sma_pkg::ADDR_W-1:0]  i_base_value,
    input  logic [sma_pkg::LIST_BITS-1:0] i_reg_list,
    input  logic                        i_write_back,
    output logic                        o_store_valid,
    output logic [sma_pkg::ADDR_W-1:0]  o_store_address,
    output logic [sma_pkg::REG_W-1:0]   o_source_reg,
    output logic                        o_unsupported,
    output logic                        o_wb_enable,
    output logic [sma_pkg::ADDR_W-1:0]  o_wb_value,
    output logic                        o_last,
    output sma_pkg::t_status            o_status
);

    localparam int LIST_W = (REG_COUNT < sma_pkg::LIST_BITS) ? REG_COUNT : sma_pkg::LIST_BITS;

    logic [LIST_W-1:0]               r_mask;
    logic [sma_pkg::ADDR_W-1:0]      r_addr;
    logic [sma_pkg::ADDR_W-1:0]      r_base_val;
    logic [sma_pkg::ADDR_W-1:0]      r_wb_val;
    logic [sma_pkg::REG_W-1:0]       r_base_reg;
    logic [sma_pkg::CNT_W-1:0]       r_count;
    logic                            r_mode;
    logic                            r_wb;
    logic                            r_unsup;

    logic [sma_pkg::CNT_W-1:0]       pop;
    logic                            base_hit;
    logic [sma_pkg::REG_W-1:0]       low_idx;
    logic [LIST_W-1:0]               mask_rest;
    logic                            single;
    logic [sma_pkg::ADDR_W-1:0]      span;
    logic [sma_pkg::ADDR_W-1:0]      base_dn;
    logic                            out_valid;
    logic                            out_acc;

    // popcount and base-in-list test
    always_comb begin
        pop      = '0;
        base_hit = 1'b0;
        for (int i = 0; i < LIST_W; i++) begin
            pop      = pop + sma_pkg::CNT_W'(r_mask[i]);
            base_hit = base_hit | (r_mask[i] & (r_base_reg == sma_pkg::REG_W'(i)));
        end
    end

    // lowest pending register
    always_comb begin
        low_idx = '0;
        for (int i = LIST_W - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_idx = sma_pkg::REG_W'(i);
            end
        end
    end

    assign mask_rest = r_mask & (r_mask - LIST_W'(1));
    assign single    = (mask_rest == '0);
    assign span      = sma_pkg::ADDR_W'({r_count, 2'b00});
    assign base_dn   = r_base_val - span;

    assign out_valid = i_ctrl.emit | i_ctrl.emit_empty;
    assign out_acc   = out_valid & i_out_ready;

    // request latch, setup and per-store update
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && i_in_valid) begin
            r_mask     <= i_reg_list[LIST_W-1:0];
            r_base_val <= i_base_value;
            r_base_reg <= i_base_reg;
            r_mode     <= i_req_type;
            r_wb       <= i_write_back;
        end
        if (i_ctrl.count) begin
            r_count <= pop;
            r_unsup <= ~r_mode & r_wb & base_hit;
        end
        if (i_ctrl.addr) begin
            r_addr <= r_mode ? base_dn : r_base_val;
            if (!r_wb) begin
                r_wb_val <= r_base_val;
            end else if (r_mode) begin
                r_wb_val <= base_dn;
            end else begin
                r_wb_val <= r_base_val + span;
            end
        end
        if (i_ctrl.emit && out_acc) begin
            r_mask <= mask_rest;
            r_addr <= r_addr + sma_pkg::ADDR_W'(sma_pkg::WORD_BYTES);
        end
    end

    // result fields; the empty-list result carries no store
    assign o_store_valid   = i_ctrl.emit & ~(r_unsup & (low_idx == r_base_reg));
    assign o_store_address = i_ctrl.emit ? r_addr : '0;
    assign o_source_reg    = i_ctrl.emit ? low_idx : '0;
    assign o_unsupported   = r_unsup;
    assign o_wb_enable     = r_wb;
    assign o_wb_value      = r_wb_val;
    assign o_last          = i_ctrl.emit_empty | single;

    assign o_status.in_acc     = i_ctrl.in_ready & i_in_valid;
    assign o_status.out_acc    = out_acc;
    assign o_status.mask_empty = (r_mask == '0);
    assign o_status.last_item  = single;

endmodule

// ----- rtl/core/sma_checker.sv -----
// Port-level checks for the store-multiple address sequencer, bound to the top.
// Depends on sma_pkg.
module sma_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [sma_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                    m_axis_tuser,
    input logic                          m_axis_tlast
);

    // one request at a time: never take a request while a result is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("request taken while a result is pending");

    // setup steps follow an accepted request
    a_setup_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (!m_axis_tvalid && !s_axis_tready))
        else $error("result shown without setup");

    // consecutive stores of one request step by one word
    a_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && (m_axis_tdata[31:0] == $past(m_axis_tdata[31:0]) + 32'd4)))
        else $error("store address did not advance by four");

    // writeback value is the same on every result of a request
    a_wb_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> $stable(m_axis_tdata[69:37]))
        else $error("writeback fields changed within a request");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
         && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind store_multiple_address_sequencer sma_checker u_sma_checker (.*);
